// ===== rtl/dtts_pkg.sv =====
// ----------------------------------------------------------------------------
// dtts_pkg
// Shared types and constants of the duration text to seconds parser.
// ----------------------------------------------------------------------------
package dtts_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_H     = 8'h68;
  localparam logic [7:0] CHAR_M     = 8'h6d;
  localparam logic [7:0] CHAR_S     = 8'h73;

  localparam logic [11:0] MULT_HOUR   = 12'd3600;
  localparam logic [11:0] MULT_MINUTE = 12'd60;
  localparam logic [11:0] MULT_SECOND = 12'd1;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_FORMAT = 3'd1;
  localparam logic [2:0] ST_UNITLESS   = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE  = 3'd3;
  localparam logic [2:0] ST_EMPTY      = 3'd4;

  typedef struct packed {
    logic       run_present;
    logic       run_overflowed;
    logic       orphan_digits;
    logic       first_seen;
    logic       first_is_zero_digit;
    logic [2:0] latched_error;
  } dtts_flags_t;

  localparam dtts_flags_t FLAGS_CLEAR = '{
    run_present:         1'b0,
    run_overflowed:      1'b0,
    orphan_digits:       1'b0,
    first_seen:          1'b0,
    first_is_zero_digit: 1'b0,
    latched_error:       ERR_NONE
  };

endpackage

// ===== rtl/duration_text_to_seconds_top.sv =====
// ----------------------------------------------------------------------------
// duration_text_to_seconds_top
// Streaming parser of a duration text such as "1h 30m 5s" into seconds.
//
//   channel  valid         stall         payload
//   text     text_valid    text_stall    character, has_character, end_of_text
//   result   result_valid  result_stall  seconds, status
//
// A character is registered on transfer and parsed from that register; the
// result of a text is loaded into the output register when its last character
// is parsed. Throughput is one character per cycle unless a stalled result
// holds back a character. Reset clears the parser state and both valids.
// A stalled result holds back only a character that ends a text.
// ----------------------------------------------------------------------------
module duration_text_to_seconds_top #(
  parameter int SECONDS_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  output logic        text_stall,
  input  logic [7:0]  character,
  input  logic        has_character,
  input  logic        end_of_text,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] seconds,
  output logic [2:0]  status
);

  logic                     hold_valid;
  logic [7:0]               hold_character;
  logic                     hold_has;
  logic                     hold_end;
  logic                     advance;
  logic                     out_free;
  logic [SECONDS_WIDTH-1:0] total;
  logic [SECONDS_WIDTH-1:0] total_next;
  logic [SECONDS_WIDTH-1:0] run_value;
  logic [SECONDS_WIDTH-1:0] run_value_next;
  dtts_pkg::dtts_flags_t    flags;
  dtts_pkg::dtts_flags_t    flags_next;
  logic [31:0]              step_seconds;
  logic [2:0]               step_status;

  assign advance    = hold_valid && (!hold_end || out_free);
  assign text_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!text_stall) begin
      hold_valid <= text_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && !text_stall) begin
      hold_character <= character;
      hold_has       <= has_character;
      hold_end       <= end_of_text;
    end
  end

  dtts_parse_step #(
    .SECONDS_WIDTH(SECONDS_WIDTH)
  ) u_step (
    .character      (hold_character),
    .has_character  (hold_has),
    .end_of_text    (hold_end),
    .total          (total),
    .run_value      (run_value),
    .flags          (flags),
    .total_next     (total_next),
    .run_value_next (run_value_next),
    .flags_next     (flags_next),
    .seconds        (step_seconds),
    .status         (step_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      run_value <= '0;
      flags     <= dtts_pkg::FLAGS_CLEAR;
    end else if (advance) begin
      total     <= total_next;
      run_value <= run_value_next;
      flags     <= flags_next;
    end
  end

  dtts_result_reg u_result (
    .clk          (clk),
    .rst          (rst),
    .load         (advance && hold_end),
    .seconds_in   (step_seconds),
    .status_in    (step_status),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .free         (out_free),
    .seconds      (seconds),
    .status       (status)
  );

endmodule

// ===== rtl/dtts_parse_step.sv =====
// ----------------------------------------------------------------------------
// dtts_parse_step
// Combinational update of the parser state for one character, and the
// result fields for an item that ends the text.
// ----------------------------------------------------------------------------
module dtts_parse_step #(
  parameter int SECONDS_WIDTH = 32
) (
  input  logic [7:0]               character,
  input  logic                     has_character,
  input  logic                     end_of_text,
  input  logic [SECONDS_WIDTH-1:0] total,
  input  logic [SECONDS_WIDTH-1:0] run_value,
  input  dtts_pkg::dtts_flags_t    flags,
  output logic [SECONDS_WIDTH-1:0] total_next,
  output logic [SECONDS_WIDTH-1:0] run_value_next,
  output dtts_pkg::dtts_flags_t    flags_next,
  output logic [31:0]              seconds,
  output logic [2:0]               status
);

  localparam int TW = SECONDS_WIDTH + 4;
  localparam int SW = SECONDS_WIDTH + 12;

  logic                     is_digit;
  logic [3:0]               digit;
  logic [11:0]              mult;
  logic                     is_unit;
  logic [TW-1:0]            run_times_ten;
  logic [SW-1:0]            scaled;
  logic [SECONDS_WIDTH:0]   sum;
  logic [63:0]              total_wide;
  dtts_pkg::dtts_flags_t    f;
  logic [SECONDS_WIDTH-1:0] tot;
  logic [SECONDS_WIDTH-1:0] rv;

  assign is_digit = (character >= dtts_pkg::CHAR_ZERO) && (character <= dtts_pkg::CHAR_NINE);
  assign digit    = 4'(character - dtts_pkg::CHAR_ZERO);

  always_comb begin
    is_unit = 1'b1;
    unique case (character)
      dtts_pkg::CHAR_H: mult = dtts_pkg::MULT_HOUR;
      dtts_pkg::CHAR_M: mult = dtts_pkg::MULT_MINUTE;
      dtts_pkg::CHAR_S: mult = dtts_pkg::MULT_SECOND;
      default: begin
        mult    = dtts_pkg::MULT_SECOND;
        is_unit = 1'b0;
      end
    endcase
  end

  assign run_times_ten = (TW'(run_value) << 3) + (TW'(run_value) << 1) + TW'(digit);
  assign scaled        = SW'(run_value) * SW'(mult);
  assign sum           = (SECONDS_WIDTH+1)'(total)
                       + (SECONDS_WIDTH+1)'(scaled[SECONDS_WIDTH-1:0]);

  always_comb begin
    f   = flags;
    tot = total;
    rv  = run_value;
    if (has_character) begin
      if (!flags.first_seen) begin
        f.first_seen          = 1'b1;
        f.first_is_zero_digit = (character == dtts_pkg::CHAR_ZERO);
      end
      if (flags.latched_error == dtts_pkg::ERR_NONE) begin
        if (is_digit) begin
          if (!flags.run_overflowed) begin
            if (run_times_ten[TW-1:SECONDS_WIDTH] != '0) begin
              f.run_overflowed = 1'b1;
            end else begin
              rv = run_times_ten[SECONDS_WIDTH-1:0];
            end
          end
          f.run_present = 1'b1;
        end else if (character == dtts_pkg::CHAR_SPACE) begin
          if (flags.run_present) begin
            f.orphan_digits = 1'b1;
          end
          f.run_present    = 1'b0;
          f.run_overflowed = 1'b0;
          rv               = '0;
        end else if (is_unit) begin
          if (flags.run_present && (flags.run_overflowed ||
              scaled[SW-1:SECONDS_WIDTH] != '0 || sum[SECONDS_WIDTH])) begin
            f.latched_error = dtts_pkg::ST_TOO_LARGE;
          end else begin
            if (flags.run_present) begin
              tot = sum[SECONDS_WIDTH-1:0];
            end
            f.run_present    = 1'b0;
            f.run_overflowed = 1'b0;
            rv               = '0;
          end
        end else begin
          f.latched_error = dtts_pkg::ST_BAD_FORMAT;
        end
      end
    end
  end

  assign total_wide = 64'(tot);

  always_comb begin
    seconds = '0;
    if (f.latched_error != dtts_pkg::ERR_NONE) begin
      status = f.latched_error;
    end else if (f.orphan_digits || f.run_present) begin
      status = dtts_pkg::ST_UNITLESS;
    end else if (tot == '0 && !f.first_is_zero_digit) begin
      status = dtts_pkg::ST_EMPTY;
    end else begin
      status  = dtts_pkg::ST_OK;
      seconds = total_wide[31:0];
    end
  end

  always_comb begin
    if (end_of_text) begin
      flags_next     = dtts_pkg::FLAGS_CLEAR;
      total_next     = '0;
      run_value_next = '0;
    end else begin
      flags_next     = f;
      total_next     = tot;
      run_value_next = rv;
    end
  end

endmodule

// ===== rtl/dtts_result_reg.sv =====
// ----------------------------------------------------------------------------
// dtts_result_reg
// Output register of the result channel; holds a result until its transfer.
// ----------------------------------------------------------------------------
module dtts_result_reg (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  logic [31:0] seconds_in,
  input  logic [2:0]  status_in,
  input  logic        result_stall,
  output logic        result_valid,
  output logic        free,
  output logic [31:0] seconds,
  output logic [2:0]  status
);

  assign free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      seconds <= seconds_in;
      status  <= status_in;
    end
  end

endmodule

// ===== tb/duration_parse_checker.sv =====
// ----------------------------------------------------------------------------
// duration_parse_checker
// Watches both channels of the duration parser. Each character transfer updates a
// local parser model, and each end of text queues the expected seconds and
// status. Every result transfer is compared with the oldest queued result.
// ----------------------------------------------------------------------------
module duration_parse_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  input  logic        text_stall,
  input  logic [7:0]  character,
  input  logic        has_character,
  input  logic        end_of_text,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic [31:0] seconds,
  input  logic [2:0]  status,
  output int          failures,
  output int          outstanding
);

  typedef struct packed {
    logic [31:0] seconds;
    logic [2:0]  status;
  } parsed_duration_t;

  localparam logic [63:0] SECONDS_MAX = 64'h0000_0000_FFFF_FFFF;

  parsed_duration_t expected_durations[$];
  parsed_duration_t oldest;

  logic [31:0] sum_seconds;
  logic [31:0] digit_value;
  logic        digits_open;
  logic        digits_overflow;
  logic        digits_cut_off;
  logic        first_taken;
  logic        first_was_zero;
  logic [2:0]  first_error;

  initial begin
    failures    = 0;
    outstanding = 0;
  end

  task automatic clear_parser();
    sum_seconds     = '0;
    digit_value     = '0;
    digits_open     = 1'b0;
    digits_overflow = 1'b0;
    digits_cut_off  = 1'b0;
    first_taken     = 1'b0;
    first_was_zero  = 1'b0;
    first_error     = dtts_pkg::ERR_NONE;
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    failures++;
    if (failures <= 10) begin
      $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
    end
  endtask

  task automatic parse_character(input logic [7:0] c);
    logic [63:0] wide_run;
    logic [63:0] wide_mult;
    logic [63:0] wide_scaled;
    logic [63:0] wide_sum;
    if (!first_taken) begin
      first_taken    = 1'b1;
      first_was_zero = (c == dtts_pkg::CHAR_ZERO);
    end
    if (first_error != dtts_pkg::ERR_NONE) return;
    if (c >= dtts_pkg::CHAR_ZERO && c <= dtts_pkg::CHAR_NINE) begin
      if (!digits_overflow) begin
        wide_run = 64'(digit_value);
        wide_run = wide_run * 64'd10 + 64'(c - dtts_pkg::CHAR_ZERO);
        if (wide_run > SECONDS_MAX) digits_overflow = 1'b1;
        else digit_value = wide_run[31:0];
      end
      digits_open = 1'b1;
      return;
    end
    if (c == dtts_pkg::CHAR_SPACE) begin
      if (digits_open) digits_cut_off = 1'b1;
      digits_open     = 1'b0;
      digits_overflow = 1'b0;
      digit_value     = '0;
      return;
    end
    case (c)
      dtts_pkg::CHAR_H: wide_mult = 64'(dtts_pkg::MULT_HOUR);
      dtts_pkg::CHAR_M: wide_mult = 64'(dtts_pkg::MULT_MINUTE);
      dtts_pkg::CHAR_S: wide_mult = 64'(dtts_pkg::MULT_SECOND);
      default: begin
        first_error = dtts_pkg::ST_BAD_FORMAT;
        return;
      end
    endcase
    if (digits_open) begin
      wide_run    = 64'(digit_value);
      wide_scaled = wide_run * wide_mult;
      wide_sum    = 64'(sum_seconds);
      wide_sum    = wide_sum + wide_scaled;
      if (digits_overflow || wide_scaled > SECONDS_MAX || wide_sum > SECONDS_MAX) begin
        first_error = dtts_pkg::ST_TOO_LARGE;
        return;
      end
      sum_seconds = wide_sum[31:0];
    end
    digits_open     = 1'b0;
    digits_overflow = 1'b0;
    digit_value     = '0;
  endtask

  task automatic finish_text();
    parsed_duration_t outcome;
    outcome.seconds = '0;
    if (first_error != dtts_pkg::ERR_NONE) begin
      outcome.status = first_error;
    end else if (digits_cut_off || digits_open) begin
      outcome.status = dtts_pkg::ST_UNITLESS;
    end else if (sum_seconds == 0 && !first_was_zero) begin
      outcome.status = dtts_pkg::ST_EMPTY;
    end else begin
      outcome.status  = dtts_pkg::ST_OK;
      outcome.seconds = sum_seconds;
    end
    expected_durations.push_back(outcome);
    clear_parser();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      expected_durations.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_durations.size() == 0) begin
          note_mismatch("result with none pending, seconds", '0, seconds);
        end else begin
          oldest = expected_durations.pop_front();
          if (seconds !== oldest.seconds) note_mismatch("seconds", oldest.seconds, seconds);
          if (status !== oldest.status) note_mismatch("status", 32'(oldest.status), 32'(status));
        end
      end
      if (text_valid && !text_stall) begin
        if (has_character) parse_character(character);
        if (end_of_text) finish_text();
      end
    end
    outstanding = expected_durations.size();
  end

endmodule

// ===== tb/duration_text_to_seconds_top_test.sv =====
// ----------------------------------------------------------------------------
// duration_text_to_seconds_top_test
// Drives duration texts into the parser: a short directed set of texts, then
// random texts built mostly from well-formed number and unit tokens with
// some noise bytes, broken-off digits and oversized values. Both sides idle
// at random, and the result side holds off for long stretches to back up
// the parser. A separate checker compares every result.
// ----------------------------------------------------------------------------
module duration_text_to_seconds_top_test;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        text_valid    = 1'b0;
  logic        text_stall;
  logic [7:0]  character     = 8'h00;
  logic        has_character = 1'b0;
  logic        end_of_text   = 1'b0;
  logic        result_valid;
  logic        result_stall  = 1'b0;
  logic [31:0] seconds;
  logic [2:0]  status;

  int          failures;
  int          outstanding;
  int          items_sent   = 0;
  bit          calm         = 1'b0;
  bit          hold_request = 1'b0;
  bit          first_hold_done  = 1'b0;
  bit          second_hold_done = 1'b0;
  logic [7:0]  text_bytes[$];

  duration_text_to_seconds_top dut (
    .clk           (clk),
    .rst           (rst),
    .text_valid    (text_valid),
    .text_stall    (text_stall),
    .character     (character),
    .has_character (has_character),
    .end_of_text   (end_of_text),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .seconds       (seconds),
    .status        (status)
  );

  duration_parse_checker checker_inst (
    .clk           (clk),
    .rst           (rst),
    .text_valid    (text_valid),
    .text_stall    (text_stall),
    .character     (character),
    .has_character (has_character),
    .end_of_text   (end_of_text),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .seconds       (seconds),
    .status        (status),
    .failures      (failures),
    .outstanding   (outstanding)
  );

  always #1 clk = ~clk;

  task automatic send_item(input logic [7:0] c, input logic has, input logic eot);
    while (!calm && $urandom_range(0, 99) < 13) begin
      text_valid <= 1'b0;
      @(posedge clk);
    end
    text_valid    <= 1'b1;
    character     <= c;
    has_character <= has;
    end_of_text   <= eot;
    @(posedge clk);
    while (text_stall) @(posedge clk);
    if (has || eot) items_sent++;
  endtask

  task automatic append_string(input string s);
    for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
  endtask

  task automatic send_text(input bit tail_empty);
    foreach (text_bytes[i]) begin
      if ($urandom_range(0, 99) < 3) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(text_bytes[i], 1'b1, !tail_empty && i == text_bytes.size() - 1);
    end
    if (tail_empty || text_bytes.size() == 0) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
    text_bytes.delete();
  endtask

  task automatic build_random_text();
    int               tokens;
    int               pick;
    longint unsigned  value;
    tokens = $urandom_range(0, 3);
    for (int t = 0; t < tokens; t++) begin
      if ($urandom_range(0, 9) == 0) text_bytes.push_back(dtts_pkg::CHAR_SPACE);
      pick = $urandom_range(0, 99);
      if (pick >= 5) begin
        if ($urandom_range(0, 9) == 0) text_bytes.push_back(dtts_pkg::CHAR_ZERO);
        if (pick < 55) begin
          value = $urandom_range(0, 99);
        end else if (pick < 78) begin
          value = $urandom_range(0, 99999);
        end else if (pick < 86) begin
          value = $urandom_range(1000000, 1200000);
        end else if (pick < 94) begin
          value = $urandom;
        end else begin
          value = $urandom;
          value = value * 10 + $urandom_range(0, 9);
        end
        append_string($sformatf("%0d", value));
        if ($urandom_range(0, 99) < 6) text_bytes.push_back(dtts_pkg::CHAR_SPACE);
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) text_bytes.push_back(dtts_pkg::CHAR_H);
      else if (pick < 60) text_bytes.push_back(dtts_pkg::CHAR_M);
      else if (pick < 92) text_bytes.push_back(dtts_pkg::CHAR_S);
      if ($urandom_range(0, 1) == 1) text_bytes.push_back(dtts_pkg::CHAR_SPACE);
    end
    if ($urandom_range(0, 99) < 8) begin
      text_bytes.insert($urandom_range(0, text_bytes.size()), 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 99) < 3) begin
      repeat ($urandom_range(1, 4)) text_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        result_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end else begin
        result_stall <= !calm && ($urandom_range(0, 99) < 13);
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    append_string("2h5s");
    send_text(1'b0);
    append_string("0s");
    send_text(1'b0);
    send_text(1'b1);
    append_string("7 s");
    send_text(1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    append_string("5s");
    send_text(1'b0);
    append_string("h");
    send_text(1'b0);
    send_item(dtts_pkg::CHAR_ZERO + 8'd3, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    append_string("2000000h");
    send_text(1'b0);

    while (items_sent < 2025) begin
      calm = (items_sent >= 1000 && items_sent < 1400);
      if (!first_hold_done && items_sent >= 400) begin
        first_hold_done = 1'b1;
        hold_request    = 1'b1;
      end
      if (!second_hold_done && items_sent >= 1600) begin
        second_hold_done = 1'b1;
        hold_request     = 1'b1;
      end
      build_random_text();
      send_text($urandom_range(0, 3) == 0);
    end
    text_valid <= 1'b0;
    calm = 1'b0;

    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
